### rtl/opl_pkg.sv
// types, character codes and token tables shared by the operator lexer
`timescale 1ns / 1ps

package opl_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_PEND  = 3'd1,
      MODE_SHIFT = 3'd2,
      MODE_LINE  = 3'd3,
      MODE_BLOCK = 3'd4,
      MODE_BSTAR = 3'd5
   } lex_mode_type;

   typedef enum logic [1:0] {
      ERR_NONE         = 2'd0,
      ERR_UNKNOWN_CHAR = 2'd1,
      ERR_OPEN_COMMENT = 2'd2
   } error_code_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] kind;
   } kind_hit_type;

   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_BAR     = 8'h7C;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_EQ      = 8'h3D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   // error results carry the semicolon code as their kind
   localparam logic [5:0] KIND_FILL          = 6'd0;
   localparam logic [5:0] KIND_LINE_COMMENT  = 6'd33;
   localparam logic [5:0] KIND_BLOCK_COMMENT = 6'd34;
   localparam logic [5:0] KIND_SHL_ASSIGN    = 6'd42;
   localparam logic [5:0] KIND_SHL           = 6'd43;
   localparam logic [5:0] KIND_SHR_ASSIGN    = 6'd46;
   localparam logic [5:0] KIND_SHR           = 6'd47;

   // punctuators that are complete after one byte
   function automatic kind_hit_type single_kind(input logic [7:0] c);
      kind_hit_type r;
      r.hit = 1'b1;
      case (c)
         CH_SEMI: r.kind = 6'd0;
         ",":     r.kind = 6'd1;
         "(":     r.kind = 6'd2;
         ")":     r.kind = 6'd3;
         "{":     r.kind = 6'd4;
         "}":     r.kind = 6'd5;
         "[":     r.kind = 6'd6;
         "]":     r.kind = 6'd7;
         "@":     r.kind = 6'd8;
         "#":     r.kind = 6'd9;
         "$":     r.kind = 6'd10;
         "?":     r.kind = 6'd11;
         "~":     r.kind = 6'd12;
         default: begin
            r.hit  = 1'b0;
            r.kind = KIND_FILL;
         end
      endcase
      return r;
   endfunction

   // operators that may grow; kind when they stand alone
   function automatic kind_hit_type lone_kind(input logic [7:0] c);
      kind_hit_type r;
      r.hit = 1'b1;
      case (c)
         CH_PERCENT: r.kind = 6'd14;
         CH_AMP:     r.kind = 6'd17;
         CH_BAR:     r.kind = 6'd20;
         "^":        r.kind = 6'd22;
         "+":        r.kind = 6'd25;
         "-":        r.kind = 6'd29;
         CH_STAR:    r.kind = 6'd32;
         CH_SLASH:   r.kind = 6'd36;
         CH_EQ:      r.kind = 6'd38;
         "!":        r.kind = 6'd40;
         CH_LT:      r.kind = 6'd44;
         CH_GT:      r.kind = 6'd48;
         CH_COLON:   r.kind = 6'd51;
         CH_DOT:     r.kind = 6'd53;
         default: begin
            r.hit  = 1'b0;
            r.kind = KIND_FILL;
         end
      endcase
      return r;
   endfunction

   function automatic kind_hit_type pair_kind(input logic [7:0] a, input logic [7:0] b);
      kind_hit_type r;
      r.hit  = 1'b0;
      r.kind = KIND_FILL;
      case (a)
         CH_PERCENT: if (b == CH_EQ) r = '{1'b1, 6'd13};
         CH_AMP: begin
            if (b == CH_AMP) r = '{1'b1, 6'd15};
            else if (b == CH_EQ) r = '{1'b1, 6'd16};
         end
         CH_BAR: begin
            if (b == CH_BAR) r = '{1'b1, 6'd18};
            else if (b == CH_EQ) r = '{1'b1, 6'd19};
         end
         "^": if (b == CH_EQ) r = '{1'b1, 6'd21};
         "+": begin
            if (b == CH_EQ) r = '{1'b1, 6'd23};
            else if (b == "+") r = '{1'b1, 6'd24};
         end
         "-": begin
            if (b == CH_GT) r = '{1'b1, 6'd26};
            else if (b == "-") r = '{1'b1, 6'd27};
            else if (b == CH_EQ) r = '{1'b1, 6'd28};
         end
         CH_STAR: begin
            if (b == CH_STAR) r = '{1'b1, 6'd30};
            else if (b == CH_EQ) r = '{1'b1, 6'd31};
         end
         CH_SLASH: if (b == CH_EQ) r = '{1'b1, 6'd35};
         CH_EQ:    if (b == CH_EQ) r = '{1'b1, 6'd37};
         "!":      if (b == CH_EQ) r = '{1'b1, 6'd39};
         CH_LT:    if (b == CH_EQ) r = '{1'b1, 6'd41};
         CH_GT:    if (b == CH_EQ) r = '{1'b1, 6'd45};
         CH_COLON: begin
            if (b == CH_COLON) r = '{1'b1, 6'd49};
            else if (b == CH_EQ) r = '{1'b1, 6'd50};
         end
         CH_DOT:   if (b == CH_DOT) r = '{1'b1, 6'd52};
         default:  r = '{1'b0, KIND_FILL};
      endcase
      return r;
   endfunction

endpackage

### rtl/operator_punctuator_lexer_top.sv
// operator and punctuator lexer: input register, lexer step, result queue
// path: a request is captured in the input register and lexed there once the queue has
//   room; its results are written to the result queue, and rsp presents them one at a time
// throughput: one request per cycle, limited by the single-result rsp port and
//   the 4-entry result queue, which must have room for two results before a step
// reset: lexer returns to idle with cleared pending state; input register and queue empty
`timescale 1ns / 1ps

module operator_punctuator_lexer_top #(
   parameter int OFFSET_BITS = 32,
   parameter int LINE_BITS   = 24,
   parameter int COLUMN_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // char_byte, byte_offset, line_number, column_number
   input  logic [((8 + OFFSET_BITS + LINE_BITS + COLUMN_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // token_class
   input  logic req_tuser,
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // token_kind, error_code, token_start, token_line, token_column
   output logic [((8 + OFFSET_BITS + LINE_BITS + COLUMN_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic rsp_tlast
);

   localparam int RSP_W = ((8 + OFFSET_BITS + LINE_BITS + COLUMN_BITS + 7) / 8) * 8;
   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 2);

   typedef struct packed {
      logic [5:0]                 kind;
      opl_pkg::error_code_type    err;
      logic [OFFSET_BITS-1:0]     start;
      logic [LINE_BITS-1:0]       line;
      logic [COLUMN_BITS-1:0]     column;
      logic                       last;
   } result_type;

   // input register
   logic                   in_valid_ff;
   logic [7:0]             char_ff;
   logic                   class_ff;
   logic                   eoi_ff;
   logic [OFFSET_BITS-1:0] offset_ff;
   logic [LINE_BITS-1:0]   line_ff;
   logic [COLUMN_BITS-1:0] column_ff;

   // lexer state
   opl_pkg::lex_mode_type  mode_ff, mode_in;
   logic [7:0]             pend_ff, pend_in;
   logic [OFFSET_BITS-1:0] sav_offset_ff, sav_offset_in;
   logic [LINE_BITS-1:0]   sav_line_ff, sav_line_in;
   logic [COLUMN_BITS-1:0] sav_column_ff, sav_column_in;

   // result queue
   result_type             queue_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic step;
   logic accept;
   logic pop;

   assign step       = in_valid_ff && (count_ff <= ROOM_LIMIT);
   assign req_tready = !in_valid_ff || step;
   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   // lexer step
   opl_pkg::kind_hit_type sk, lk, pk, pair;
   logic                    sb_emit;
   logic                    sb_pend;
   logic [5:0]              sb_kind;
   opl_pkg::error_code_type sb_err;
   logic [5:0]              flush_kind;
   opl_pkg::error_code_type flush_err;
   logic [5:0]              shift_kind;
   logic                    saved_emit;
   logic [5:0]              saved_kind;
   opl_pkg::error_code_type saved_err;
   logic                    do_start;
   logic                    fresh_emit;
   result_type              saved_res, fresh_res, first_res;
   logic [1:0]              res_count;

   always_comb begin
      sk      = opl_pkg::single_kind(char_ff);
      lk      = opl_pkg::lone_kind(char_ff);
      pk      = opl_pkg::lone_kind(pend_ff);
      pair    = opl_pkg::pair_kind(pend_ff, char_ff);
      sb_emit = class_ff && (sk.hit || !lk.hit);
      sb_pend = class_ff && !sk.hit && lk.hit;
      sb_kind = sk.hit ? sk.kind : opl_pkg::KIND_FILL;
      sb_err  = sk.hit ? opl_pkg::ERR_NONE : opl_pkg::ERR_UNKNOWN_CHAR;
      flush_kind = pk.hit ? pk.kind : opl_pkg::KIND_FILL;
      flush_err  = pk.hit ? opl_pkg::ERR_NONE : opl_pkg::ERR_UNKNOWN_CHAR;
      shift_kind = (pend_ff == opl_pkg::CH_LT) ? opl_pkg::KIND_SHL : opl_pkg::KIND_SHR;

      mode_in    = mode_ff;
      saved_emit = 1'b0;
      saved_kind = opl_pkg::KIND_FILL;
      saved_err  = opl_pkg::ERR_NONE;
      do_start   = 1'b0;

      if (eoi_ff) begin
         mode_in = opl_pkg::MODE_IDLE;
         case (mode_ff)
            opl_pkg::MODE_PEND: begin
               saved_emit = 1'b1;
               saved_kind = flush_kind;
               saved_err  = flush_err;
            end
            opl_pkg::MODE_SHIFT: begin
               saved_emit = 1'b1;
               saved_kind = shift_kind;
            end
            opl_pkg::MODE_LINE: begin
               saved_emit = 1'b1;
               saved_kind = opl_pkg::KIND_LINE_COMMENT;
            end
            opl_pkg::MODE_BLOCK, opl_pkg::MODE_BSTAR: begin
               saved_emit = 1'b1;
               saved_err  = opl_pkg::ERR_OPEN_COMMENT;
            end
            default: saved_emit = 1'b0;
         endcase
      end else begin
         case (mode_ff)
            opl_pkg::MODE_PEND: begin
               if (pend_ff == opl_pkg::CH_SLASH && char_ff == opl_pkg::CH_SLASH) begin
                  mode_in = opl_pkg::MODE_LINE;
               end else if (pend_ff == opl_pkg::CH_SLASH && char_ff == opl_pkg::CH_STAR) begin
                  mode_in = opl_pkg::MODE_BLOCK;
               end else if ((pend_ff == opl_pkg::CH_LT || pend_ff == opl_pkg::CH_GT)
                            && char_ff == pend_ff) begin
                  mode_in = opl_pkg::MODE_SHIFT;
               end else if (pair.hit) begin
                  saved_emit = 1'b1;
                  saved_kind = pair.kind;
                  mode_in    = opl_pkg::MODE_IDLE;
               end else begin
                  saved_emit = 1'b1;
                  saved_kind = flush_kind;
                  saved_err  = flush_err;
                  do_start   = 1'b1;
               end
            end
            opl_pkg::MODE_SHIFT: begin
               saved_emit = 1'b1;
               if (char_ff == opl_pkg::CH_EQ) begin
                  saved_kind = (pend_ff == opl_pkg::CH_LT) ? opl_pkg::KIND_SHL_ASSIGN
                                                           : opl_pkg::KIND_SHR_ASSIGN;
                  mode_in    = opl_pkg::MODE_IDLE;
               end else begin
                  saved_kind = shift_kind;
                  do_start   = 1'b1;
               end
            end
            opl_pkg::MODE_LINE: begin
               // newline closes the comment and is then lexed itself
               if (char_ff == opl_pkg::CH_NEWLINE) begin
                  saved_emit = 1'b1;
                  saved_kind = opl_pkg::KIND_LINE_COMMENT;
                  do_start   = 1'b1;
               end
            end
            opl_pkg::MODE_BLOCK: begin
               if (char_ff == opl_pkg::CH_STAR) mode_in = opl_pkg::MODE_BSTAR;
            end
            opl_pkg::MODE_BSTAR: begin
               if (char_ff == opl_pkg::CH_SLASH) begin
                  saved_emit = 1'b1;
                  saved_kind = opl_pkg::KIND_BLOCK_COMMENT;
                  mode_in    = opl_pkg::MODE_IDLE;
               end else if (char_ff != opl_pkg::CH_STAR) begin
                  mode_in = opl_pkg::MODE_BLOCK;
               end
            end
            default: do_start = 1'b1;
         endcase
      end

      pend_in       = pend_ff;
      sav_offset_in = sav_offset_ff;
      sav_line_in   = sav_line_ff;
      sav_column_in = sav_column_ff;
      if (do_start) begin
         mode_in = sb_pend ? opl_pkg::MODE_PEND : opl_pkg::MODE_IDLE;
         if (sb_pend) begin
            pend_in       = char_ff;
            sav_offset_in = offset_ff;
            sav_line_in   = line_ff;
            sav_column_in = column_ff;
         end
      end

      fresh_emit = do_start && sb_emit;
      res_count  = {1'b0, saved_emit} + {1'b0, fresh_emit};

      saved_res = '{kind: saved_kind, err: saved_err, start: sav_offset_ff,
                    line: sav_line_ff, column: sav_column_ff, last: !fresh_emit};
      fresh_res = '{kind: sb_kind, err: sb_err, start: offset_ff,
                    line: line_ff, column: column_ff, last: 1'b1};
      first_res = saved_emit ? saved_res : fresh_res;
   end

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (step) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(res_count);
         count_in  = count_ff + CNT_W'(res_count);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
         count_in  = count_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         mode_ff       <= opl_pkg::MODE_IDLE;
         pend_ff       <= '0;
         sav_offset_ff <= '0;
         sav_line_ff   <= '0;
         sav_column_ff <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (step) begin
            mode_ff       <= mode_in;
            pend_ff       <= pend_in;
            sav_offset_ff <= sav_offset_in;
            sav_line_ff   <= sav_line_in;
            sav_column_ff <= sav_column_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff   <= req_tdata[7:0];
         class_ff  <= req_tuser;
         eoi_ff    <= req_tlast;
         offset_ff <= req_tdata[8 +: OFFSET_BITS];
         line_ff   <= req_tdata[8 + OFFSET_BITS +: LINE_BITS];
         column_ff <= req_tdata[8 + OFFSET_BITS + LINE_BITS +: COLUMN_BITS];
      end
      if (step && res_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= first_res;
      end
      if (step && saved_emit && fresh_emit) begin
         queue_ff[wr_ptr_ff + PTR_W'(1)] <= fresh_res;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last;
   assign rsp_tdata  = RSP_W'({queue_ff[rd_ptr_ff].column, queue_ff[rd_ptr_ff].line,
                               queue_ff[rd_ptr_ff].start, queue_ff[rd_ptr_ff].err,
                               queue_ff[rd_ptr_ff].kind});

endmodule

### tb/sv/operator_punctuator_lexer_top_tb.sv
// self-checking testbench for the operator and punctuator lexer
`timescale 1ns / 1ps

module operator_punctuator_lexer_top_tb;

   localparam int NUM_KINDS = 54;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [5:0]              kind;
      opl_pkg::error_code_type err;
      logic [31:0]             start;
      logic [23:0]             line;
      logic [15:0]             column;
      logic                    last;
   } token_rec_type;

   // token spellings, indexed by kind; the line comment stands for its opener, the block comment for opener and closer
   string token_text [NUM_KINDS] = '{
      ";", ",", "(", ")", "{", "}", "[", "]", "@", "#", "$", "?", "~",
      "%=", "%", "&&", "&=", "&", "||", "|=", "|", "^=", "^",
      "+=", "++", "+", "->", "--", "-=", "-", "**", "*=", "*",
      "//", "/**/", "/=", "/", "==", "=", "!=", "!", "<=", "<<=", "<<", "<",
      ">=", ">>=", ">>", ">", "::", ":=", ":", "..", "."};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tlast;

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic        hold_req = 1'b0;
   int          fail_count = 0;

   logic [31:0] pos_off = '0;
   logic [23:0] pos_line = '0;
   logic [15:0] pos_col = '0;

   // predictor state
   opl_pkg::lex_mode_type lx_mode = opl_pkg::MODE_IDLE;
   logic [7:0]            lx_pend = '0;
   logic [31:0]           lx_off = '0;
   logic [23:0]           lx_line = '0;
   logic [15:0]           lx_col = '0;
   token_rec_type         step_out [$];
   token_rec_type         expected_tokens [$];

   operator_punctuator_lexer_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("FAIL operator_punctuator_lexer_top");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int token_index(input logic [7:0] a, input logic [7:0] b, input int n);
      for (int i = 0; i < NUM_KINDS; i++) begin
         if (token_text[i].len() == n && token_text[i][0] == a &&
             (n == 1 || token_text[i][1] == b))
            return i;
      end
      return -1;
   endfunction

   // a lone char that some longer token starts with has to wait for the next byte
   function automatic bit can_grow(input logic [7:0] c);
      for (int i = 0; i < NUM_KINDS; i++) begin
         if (token_text[i].len() >= 2 && token_text[i][0] == c) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void push_token(input logic [5:0] kind,
                                      input opl_pkg::error_code_type err,
                                      input logic [31:0] o, input logic [23:0] l,
                                      input logic [15:0] col);
      token_rec_type t;
      t.kind   = kind;
      t.err    = err;
      t.start  = o;
      t.line   = l;
      t.column = col;
      t.last   = 1'b0;
      step_out.push_back(t);
   endfunction

   function automatic void push_saved(input logic [5:0] kind,
                                      input opl_pkg::error_code_type err);
      push_token(kind, err, lx_off, lx_line, lx_col);
   endfunction

   function automatic void flush_pending();
      int k;
      k = token_index(lx_pend, 8'h00, 1);
      if (k >= 0) push_saved(6'(k), opl_pkg::ERR_NONE);
      else push_saved(opl_pkg::KIND_FILL, opl_pkg::ERR_UNKNOWN_CHAR);
   endfunction

   function automatic void start_fresh(input logic [7:0] c, input logic cls,
                                       input logic [31:0] o, input logic [23:0] l,
                                       input logic [15:0] col);
      int k;
      lx_mode = opl_pkg::MODE_IDLE;
      if (cls) begin
         k = token_index(c, 8'h00, 1);
         if (k < 0) begin
            push_token(opl_pkg::KIND_FILL, opl_pkg::ERR_UNKNOWN_CHAR, o, l, col);
         end else if (can_grow(c)) begin
            lx_mode = opl_pkg::MODE_PEND;
            lx_pend = c;
            lx_off  = o;
            lx_line = l;
            lx_col  = col;
         end else begin
            push_token(6'(k), opl_pkg::ERR_NONE, o, l, col);
         end
      end
   endfunction

   function automatic void predict_tokens(input logic [7:0] c, input logic cls, input logic eof,
                                          input logic [31:0] o, input logic [23:0] l,
                                          input logic [15:0] col);
      int k;
      step_out.delete();
      if (eof) begin
         case (lx_mode)
            opl_pkg::MODE_PEND:  flush_pending();
            opl_pkg::MODE_SHIFT: begin
               push_saved(lx_pend == opl_pkg::CH_LT ? opl_pkg::KIND_SHL : opl_pkg::KIND_SHR,
                          opl_pkg::ERR_NONE);
            end
            opl_pkg::MODE_LINE:  push_saved(opl_pkg::KIND_LINE_COMMENT, opl_pkg::ERR_NONE);
            opl_pkg::MODE_BLOCK, opl_pkg::MODE_BSTAR: begin
               push_saved(opl_pkg::KIND_FILL, opl_pkg::ERR_OPEN_COMMENT);
            end
            default: ;
         endcase
         lx_mode = opl_pkg::MODE_IDLE;
      end else begin
         case (lx_mode)
            opl_pkg::MODE_PEND: begin
               k = token_index(lx_pend, c, 2);
               if (lx_pend == opl_pkg::CH_SLASH && c == opl_pkg::CH_SLASH) begin
                  lx_mode = opl_pkg::MODE_LINE;
               end else if (lx_pend == opl_pkg::CH_SLASH && c == opl_pkg::CH_STAR) begin
                  lx_mode = opl_pkg::MODE_BLOCK;
               end else if ((lx_pend == opl_pkg::CH_LT || lx_pend == opl_pkg::CH_GT) &&
                            c == lx_pend) begin
                  lx_mode = opl_pkg::MODE_SHIFT;
               end else if (k >= 0) begin
                  push_saved(6'(k), opl_pkg::ERR_NONE);
                  lx_mode = opl_pkg::MODE_IDLE;
               end else begin
                  flush_pending();
                  start_fresh(c, cls, o, l, col);
               end
            end
            opl_pkg::MODE_SHIFT: begin
               if (c == opl_pkg::CH_EQ) begin
                  push_saved(lx_pend == opl_pkg::CH_LT ? opl_pkg::KIND_SHL_ASSIGN
                                                       : opl_pkg::KIND_SHR_ASSIGN,
                             opl_pkg::ERR_NONE);
                  lx_mode = opl_pkg::MODE_IDLE;
               end else begin
                  push_saved(lx_pend == opl_pkg::CH_LT ? opl_pkg::KIND_SHL : opl_pkg::KIND_SHR,
                             opl_pkg::ERR_NONE);
                  start_fresh(c, cls, o, l, col);
               end
            end
            opl_pkg::MODE_LINE: begin
               if (c == opl_pkg::CH_NEWLINE) begin
                  push_saved(opl_pkg::KIND_LINE_COMMENT, opl_pkg::ERR_NONE);
                  start_fresh(c, cls, o, l, col);
               end
            end
            opl_pkg::MODE_BLOCK: begin
               if (c == opl_pkg::CH_STAR) lx_mode = opl_pkg::MODE_BSTAR;
            end
            opl_pkg::MODE_BSTAR: begin
               if (c == opl_pkg::CH_SLASH) begin
                  push_saved(opl_pkg::KIND_BLOCK_COMMENT, opl_pkg::ERR_NONE);
                  lx_mode = opl_pkg::MODE_IDLE;
               end else if (c != opl_pkg::CH_STAR) begin
                  lx_mode = opl_pkg::MODE_BLOCK;
               end
            end
            default: start_fresh(c, cls, o, l, col);
         endcase
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
   endfunction

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         predict_tokens(req_tdata[7:0], req_tuser, req_tlast,
                        req_tdata[39:8], req_tdata[63:40], req_tdata[79:64]);
   end

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin
      token_rec_type want;
      token_rec_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind   = rsp_tdata[5:0];
         got.err    = opl_pkg::error_code_type'(rsp_tdata[7:6]);
         got.start  = rsp_tdata[39:8];
         got.line   = rsp_tdata[63:40];
         got.column = rsp_tdata[79:64];
         got.last   = rsp_tlast;
         if (expected_tokens.size() == 0) begin
            fail_count++;
            $display("%0t unexpected token: kind %0d err %0d start %h line %h col %h last %0d",
                     $time, got.kind, got.err, got.start, got.line, got.column, got.last);
         end else begin
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind || got.err !== want.err || got.start !== want.start ||
                got.line !== want.line || got.column !== want.column ||
                got.last !== want.last) begin
               fail_count++;
               $display("%0t mismatch: expected kind %0d err %0d start %h line %h col %h last %0d",
                        $time, want.kind, want.err, want.start, want.line, want.column,
                        want.last);
               $display("%0t          actual   kind %0d err %0d start %h line %h col %h last %0d",
                        $time, got.kind, got.err, got.start, got.line, got.column, got.last);
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            // long hold-off so the result queue fills and the input stalls
            hold_req   <= 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- sender

   task automatic send_byte(input logic [7:0] c, input logic cls, input logic eof);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pos_col, pos_line, pos_off, c};
      req_tuser  <= cls;
      req_tlast  <= eof;
      do @(posedge clock); while (!req_tready);
      if ($urandom_range(99) < 3) begin
         pos_off  = $urandom;
         pos_line = 24'($urandom);
         pos_col  = 16'($urandom);
      end else begin
         pos_off = pos_off + 32'd1;
         if (c == opl_pkg::CH_NEWLINE) begin
            pos_line = pos_line + 24'd1;
            pos_col  = '0;
         end else begin
            pos_col = pos_col + 16'd1;
         end
      end
   endtask

   task automatic send_text(input string s);
      logic cls;
      for (int i = 0; i < s.len(); i++) begin
         cls = (i == 0) || ($urandom_range(9) != 0);
         send_byte(s[i], cls, 1'b0);
      end
   endtask

   task automatic send_line_comment();
      logic [7:0] b;
      int n;
      send_text("//");
      n = $urandom_range(0, 5);
      repeat (n) begin
         b = 8'($urandom_range(255));
         if (b == opl_pkg::CH_NEWLINE) b = opl_pkg::CH_SEMI;
         send_byte(b, 1'($urandom_range(1)), 1'b0);
      end
      if ($urandom_range(99) < 85) begin
         send_byte(opl_pkg::CH_NEWLINE, 1'($urandom_range(1)), 1'b0);
      end else begin
         send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      end
   endtask

   task automatic send_block_comment();
      logic [7:0] b;
      logic prev_star;
      int n;
      send_text("/*");
      prev_star = 1'b0;
      n = $urandom_range(0, 6);
      repeat (n) begin
         case ($urandom_range(3))
            0: b = opl_pkg::CH_STAR;
            1: b = opl_pkg::CH_SLASH;
            default: b = 8'($urandom_range(255));
         endcase
         // keep the comment open until the planned closer
         if (prev_star && b == opl_pkg::CH_SLASH) b = opl_pkg::CH_STAR;
         prev_star = (b == opl_pkg::CH_STAR);
         send_byte(b, 1'($urandom_range(1)), 1'b0);
      end
      if ($urandom_range(99) < 85) begin
         send_byte(opl_pkg::CH_STAR, 1'($urandom_range(1)), 1'b0);
         send_byte(opl_pkg::CH_SLASH, 1'($urandom_range(1)), 1'b0);
      end else begin
         send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_extremes();
      pos_off  = '0;
      pos_line = '0;
      pos_col  = '0;
      send_byte(opl_pkg::CH_SEMI, 1'b1, 1'b0);
      pos_off  = '1;
      pos_line = '1;
      pos_col  = '1;
      send_byte("@", 1'b1, 1'b0);
   endtask

   task automatic test_shifts();
      send_text("<<=");
      send_text(">>;");
   endtask

   task automatic test_comments();
      // newline flagged after a line comment: comment, then unknown char
      send_byte(opl_pkg::CH_SLASH, 1'b1, 1'b0);
      send_byte(opl_pkg::CH_SLASH, 1'b1, 1'b0);
      send_byte(opl_pkg::CH_NEWLINE, 1'b1, 1'b0);
      // the slash right after the opener does not close the comment
      send_text("/*/*/");
   endtask

   task automatic test_unflagged();
      send_byte("x", 1'b0, 1'b0);
      send_byte("a", 1'b1, 1'b0);
      send_byte("+", 1'b1, 1'b0);
      send_byte("+", 1'b0, 1'b0);
      send_byte("-", 1'b1, 1'b0);
      send_byte("a", 1'b0, 1'b0);
   endtask

   task automatic test_end_of_input();
      send_byte(8'hFF, 1'b1, 1'b1);
      send_byte(opl_pkg::CH_AMP, 1'b1, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);
      send_text("/*");
      send_byte(opl_pkg::CH_STAR, 1'b1, 1'b1);
      send_text("//");
      send_byte(opl_pkg::CH_SLASH, 1'b0, 1'b1);
      send_text(">>");
      send_byte(8'hFF, 1'b1, 1'b1);
   endtask

   task automatic random_tokens(input int count);
      int idx;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            idx = $urandom_range(NUM_KINDS - 1);
            if (idx == opl_pkg::KIND_LINE_COMMENT) send_line_comment();
            else if (idx == opl_pkg::KIND_BLOCK_COMMENT) send_block_comment();
            else send_text(token_text[idx]);
            if ($urandom_range(99) < 30) send_byte(" ", 1'b0, 1'b0);
         end else if (pick < 65) begin
            send_line_comment();
         end else if (pick < 75) begin
            send_block_comment();
         end else if (pick < 80) begin
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
         end else begin
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
         end
      end
   endtask

   task automatic test_backpressure();
      hold_req <= 1'b1;
      random_tokens(50);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 11;
      recv_idle_pct = 61;
      test_extremes();
      test_shifts();
      test_comments();
      test_unflagged();
      test_end_of_input();
      random_tokens(200);
      send_idle_pct = 61;
      recv_idle_pct = 11;
      random_tokens(200);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      random_tokens(150);
      req_tvalid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_tokens.size() == 0) begin
         $display("PASS operator_punctuator_lexer_top");
      end else begin
         $display("FAIL operator_punctuator_lexer_top");
      end
      $finish;
   end

endmodule
